// File: hw/rtl/assert_macros.svh
// Assertion macros used by the velocity reference unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, off during reset.
`define ASSERT_IMPLIES(label, ck, rn, cond, expr, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge, off during reset.
`define ASSERT_NEXT(label, ck, rn, cond, expr, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: hw/rtl/jvr_pkg.sv
// Types and fixed constants of the joystick velocity reference unit.
`default_nettype none

package jvr_pkg;

    typedef logic [3:0]  reg_index_t;
    typedef logic [15:0] cfg_data_t;
    typedef logic [30:0] q30_t;

    // Configuration register indexes
    localparam reg_index_t REG_DEADZONE_WIDTH   = 4'd0;
    localparam reg_index_t REG_LOCAL_FRAME_MODE = 4'd1;
    localparam reg_index_t REG_X_GAIN_FROM_X    = 4'd2;
    localparam reg_index_t REG_X_GAIN_FROM_Y    = 4'd3;
    localparam reg_index_t REG_Y_GAIN_FROM_X    = 4'd4;
    localparam reg_index_t REG_Y_GAIN_FROM_Y    = 4'd5;
    localparam reg_index_t REG_MAX_SPEED_X      = 4'd6;
    localparam reg_index_t REG_MAX_SPEED_Y      = 4'd7;

    // Quarter-wave sine polynomial coefficients, Q30
    localparam q30_t COEF_A = 31'd1686629713;
    localparam q30_t COEF_B = 31'd688904866;
    localparam q30_t COEF_C = 31'd76016977;

    // Reset values of the configuration registers
    localparam logic [15:0]        DEADZONE_RST = 16'd0;
    localparam logic signed [15:0] GAIN_ONE_RST = 16'sd16384;
    localparam logic signed [15:0] GAIN_ZERO_RST = 16'sd0;
    localparam logic [15:0]        SPEED_RST    = 16'd4096;

endpackage

`default_nettype wire

// File: hw/rtl/joystick_velocity_reference_unit.sv
// Joystick velocity reference: dead zone, remap, speed scale, heading rotation, position.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | to block  | in_valid/in_ready   | operation axis_x axis_y pos_x pos_y
//           |           |                     | heading horizon
//   out     | from block| out_valid/out_ready | vel_x vel_y new_pos_x new_pos_y
//   cfg     | to block  | cfg_valid/cfg_ready | cfg_index cfg_data
//
// One item at a time. All products go through one bit-serial multiply-accumulate
// unit (one multiplier bit per cycle) and the dead-zone rescale through one
// restoring divider (one quotient bit per cycle); these set the latency.
// Query: local-frame mode adds two sine passes of four 32-bit multiplies each
// and four 32-bit rotation multiplies.
// Reset: asynchronous, active low; clears control, config and velocity state.
// A finished result waits in the output register; the next beat is taken
// meanwhile and the engine holds at its end until the output register frees.
`default_nettype none
`include "assert_macros.svh"

module joystick_velocity_reference_unit #(
    parameter int AXIS_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  jvr_pkg::reg_index_t cfg_index,
    input  jvr_pkg::cfg_data_t  cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic signed [15:0]  axis_x,
    input  logic signed [15:0]  axis_y,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic [15:0]         heading,
    input  logic [15:0]         horizon,

    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  vel_x,
    output logic signed [31:0]  vel_y,
    output logic signed [31:0]  new_pos_x,
    output logic signed [31:0]  new_pos_y
);

    import jvr_pkg::*;

    localparam int NW        = AXIS_BITS + 1;
    localparam int QB        = ANGLE_BITS - 2;
    localparam int VEL_SHIFT = AXIS_BITS + 9;

    localparam logic [31:0]            FS32    = 32'd1 << (AXIS_BITS - 1);
    localparam logic [AXIS_BITS-1:0]   FS_N    = AXIS_BITS'(1) << (AXIS_BITS - 1);
    localparam logic [ANGLE_BITS-1:0]  QUARTER = ANGLE_BITS'(1) << QB;
    localparam logic [QB:0]            QQ      = (QB + 1)'(1) << QB;
    localparam logic signed [63:0]     VEL_HALF = 64'sd1 <<< (VEL_SHIFT - 1);
    localparam logic signed [63:0]     ROT_HALF = 64'sd1 <<< 15;
    localparam logic signed [63:0]     POS_HALF = 64'sd1 <<< 11;
    localparam logic signed [63:0]     SAT_MAX  = 64'sd2147483647;
    localparam logic signed [63:0]     SAT_MIN  = -64'sd2147483648;

    localparam logic [4:0] AXIS_LAST = 5'(AXIS_BITS - 1);
    localparam logic [4:0] NB_AXIS   = 5'(AXIS_BITS);
    localparam logic [4:0] NB_U16    = 5'd16;
    localparam logic [4:0] NB_W32    = 5'd31;

    // Sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DZ_X = 5'd1;
    localparam logic [4:0] ST_NX   = 5'd2;
    localparam logic [4:0] ST_DZ_Y = 5'd3;
    localparam logic [4:0] ST_NY   = 5'd4;
    localparam logic [4:0] ST_MX0  = 5'd5;
    localparam logic [4:0] ST_MX1  = 5'd6;
    localparam logic [4:0] ST_SX   = 5'd7;
    localparam logic [4:0] ST_VX   = 5'd8;
    localparam logic [4:0] ST_MY0  = 5'd9;
    localparam logic [4:0] ST_MY1  = 5'd10;
    localparam logic [4:0] ST_SY   = 5'd11;
    localparam logic [4:0] ST_VY   = 5'd12;
    localparam logic [4:0] ST_Q0   = 5'd13;
    localparam logic [4:0] ST_SIN0 = 5'd14;
    localparam logic [4:0] ST_SIN1 = 5'd15;
    localparam logic [4:0] ST_SIN2 = 5'd16;
    localparam logic [4:0] ST_SIN3 = 5'd17;
    localparam logic [4:0] ST_SIN4 = 5'd18;
    localparam logic [4:0] ST_RX0  = 5'd19;
    localparam logic [4:0] ST_RX1  = 5'd20;
    localparam logic [4:0] ST_RX2  = 5'd21;
    localparam logic [4:0] ST_RY1  = 5'd22;
    localparam logic [4:0] ST_RY2  = 5'd23;
    localparam logic [4:0] ST_PX0  = 5'd24;
    localparam logic [4:0] ST_PX1  = 5'd25;
    localparam logic [4:0] ST_PY1  = 5'd26;
    localparam logic [4:0] ST_FIN  = 5'd27;
    localparam logic [4:0] ST_MUL  = 5'd28;
    localparam logic [4:0] ST_DIV  = 5'd29;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT_MIN)
            r = $signed(32'h8000_0000);
        else
            r = v[31:0];
        return r;
    endfunction

    // Control state
    logic [4:0]  state_reg;
    logic [4:0]  ret_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  nb_reg;
    logic        sub_reg;
    logic        cos_pass_reg;
    logic        out_valid_reg;

    // Configuration
    logic [15:0]        dz_width_reg;
    logic               local_mode_reg;
    logic signed [15:0] gxx_reg;
    logic signed [15:0] gxy_reg;
    logic signed [15:0] gyx_reg;
    logic signed [15:0] gyy_reg;
    logic [15:0]        spd_x_reg;
    logic [15:0]        spd_y_reg;

    // Stored reference velocity
    logic signed [31:0] vel_x_reg;
    logic signed [31:0] vel_y_reg;

    // Latched item
    logic               op_reg;
    logic [15:0]        ax_reg;
    logic [15:0]        ay_reg;
    logic signed [31:0] px_in_reg;
    logic signed [31:0] py_in_reg;
    logic [15:0]        head_reg;
    logic [15:0]        hor_reg;

    // Serial datapath
    logic signed [63:0]    acc_reg;
    logic signed [63:0]    mc_reg;
    logic signed [31:0]    mp_reg;
    logic [AXIS_BITS:0]    rem_reg;
    logic [AXIS_BITS-1:0]  dvs_reg;
    logic [AXIS_BITS-1:0]  quo_reg;
    logic                  dneg_reg;
    logic signed [NW-1:0]  nx_reg;
    logic signed [NW-1:0]  ny_reg;
    logic [30:0]           z_reg;
    logic [30:0]           z2_reg;
    logic [1:0]            quad_reg;
    logic signed [17:0]    s_reg;
    logic signed [17:0]    c_reg;
    logic signed [33:0]    rx_reg;
    logic signed [33:0]    ry_reg;
    logic signed [31:0]    npx_reg;
    logic signed [31:0]    npy_reg;

    // Output register
    logic signed [31:0] vel_x_out_reg;
    logic signed [31:0] vel_y_out_reg;
    logic signed [31:0] pos_x_out_reg;
    logic signed [31:0] pos_y_out_reg;

    logic in_accept;
    logic fin_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign fin_load  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // ---------------- dead zone front end ----------------
    logic [39:0]                ax_wide;
    logic [39:0]                ay_wide;
    logic signed [AXIS_BITS-1:0] axis_cur;
    logic [AXIS_BITS-1:0]       axis_u;
    logic [AXIS_BITS-1:0]       mag;
    logic [31:0]                dz32;
    logic                       dz_off;
    logic [AXIS_BITS-1:0]       d_n;
    logic                       in_dz;
    logic                       dz_direct;
    logic signed [NW-1:0]       direct_val;

    assign ax_wide  = {24'b0, ax_reg};
    assign ay_wide  = {24'b0, ay_reg};
    assign axis_cur = (state_reg == ST_DZ_Y) ? $signed(ay_wide[AXIS_BITS-1:0])
                                             : $signed(ax_wide[AXIS_BITS-1:0]);
    assign axis_u   = axis_cur;
    assign mag      = axis_cur[AXIS_BITS-1] ? AXIS_BITS'(~axis_u + 1'b1) : axis_u;
    assign dz32     = 32'(dz_width_reg);
    assign dz_off   = (dz32 >= FS32);
    assign d_n      = dz32[AXIS_BITS-1:0];
    assign in_dz    = (mag <= d_n);
    assign dz_direct  = dz_off || in_dz;
    assign direct_val = dz_off ? NW'(axis_cur) : '0;

    // Restoring divider step: one quotient bit per cycle
    logic [AXIS_BITS:0]   div_cand;
    logic                 div_ge;
    logic [NW-1:0]        quo_ext;
    logic signed [NW-1:0] div_val;

    assign div_cand = (cnt_reg == 5'd0) ? rem_reg : {rem_reg[AXIS_BITS-1:0], 1'b0};
    assign div_ge   = (div_cand >= {1'b0, dvs_reg});
    assign quo_ext  = {1'b0, quo_reg};
    assign div_val  = dneg_reg ? -$signed(quo_ext) : $signed(quo_ext);

    // ---------------- bit-serial multiply-accumulate ----------------
    logic               mac_last;
    logic               mac_neg;
    logic signed [63:0] mac_addend;
    logic signed [63:0] acc_step;

    assign mac_last   = (cnt_reg == nb_reg);
    assign mac_neg    = mac_last ^ sub_reg;   // top bit negative; sub_reg flips all signs
    assign mac_addend = mac_neg ? -mc_reg : mc_reg;
    assign acc_step   = mp_reg[0] ? acc_reg + mac_addend : acc_reg;

    // Rounding shifts (half toward plus infinity) and saturation
    logic signed [63:0] vel_rnd;
    logic signed [63:0] rot_rnd;
    logic signed [63:0] pos_rnd;
    logic signed [31:0] pos_cur;
    logic signed [31:0] vel_sat;
    logic signed [31:0] pos_sat;

    assign vel_rnd = (acc_reg + VEL_HALF) >>> VEL_SHIFT;
    assign rot_rnd = (acc_reg + ROT_HALF) >>> 16;
    assign pos_rnd = (acc_reg + POS_HALF) >>> 12;
    assign pos_cur = (state_reg == ST_PY1) ? py_in_reg : px_in_reg;
    assign vel_sat = sat32(vel_rnd);
    assign pos_sat = sat32(64'(pos_cur) + pos_rnd);

    // ---------------- sine front and back end ----------------
    logic [39:0]             hd_wide;
    logic [ANGLE_BITS-1:0]   ang;
    logic [1:0]              quad;
    logic [QB:0]             rfold;
    logic [30:0]             zval;
    logic [30:0]             sh30;
    logic [31:0]             t_rnd;
    logic [17:0]             t_mag;
    logic signed [17:0]      sine_val;

    assign hd_wide  = {24'b0, head_reg};
    assign ang      = hd_wide[ANGLE_BITS-1:0] + (cos_pass_reg ? QUARTER : '0);
    assign quad     = ang[ANGLE_BITS-1 -: 2];
    assign rfold    = quad[0] ? QQ - {1'b0, ang[QB-1:0]} : {1'b0, ang[QB-1:0]};
    assign zval     = {rfold, {(30 - QB){1'b0}}};
    assign sh30     = acc_reg[60:30];
    assign t_rnd    = 32'(sh30) + 32'd8192;
    assign t_mag    = t_rnd[31:14];
    assign sine_val = quad_reg[1] ? -$signed(t_mag) : $signed(t_mag);

    // ---------------- control: sequencer, config, velocity ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            cnt_reg        <= '0;
            nb_reg         <= '0;
            sub_reg        <= 1'b0;
            cos_pass_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            dz_width_reg   <= DEADZONE_RST;
            local_mode_reg <= 1'b0;
            gxx_reg        <= GAIN_ONE_RST;
            gxy_reg        <= GAIN_ZERO_RST;
            gyx_reg        <= GAIN_ZERO_RST;
            gyy_reg        <= GAIN_ONE_RST;
            spd_x_reg      <= SPEED_RST;
            spd_y_reg      <= SPEED_RST;
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_DEADZONE_WIDTH:   dz_width_reg   <= cfg_data;
                    REG_LOCAL_FRAME_MODE: local_mode_reg <= cfg_data[0];
                    REG_X_GAIN_FROM_X:    gxx_reg        <= $signed(cfg_data);
                    REG_X_GAIN_FROM_Y:    gxy_reg        <= $signed(cfg_data);
                    REG_Y_GAIN_FROM_X:    gyx_reg        <= $signed(cfg_data);
                    REG_Y_GAIN_FROM_Y:    gyy_reg        <= $signed(cfg_data);
                    REG_MAX_SPEED_X:      spd_x_reg      <= cfg_data;
                    REG_MAX_SPEED_Y:      spd_y_reg      <= cfg_data;
                    default:              ;
                endcase
            end

            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= operation ? ST_Q0 : ST_DZ_X;
                end
                ST_DZ_X:
                begin
                    cnt_reg <= '0;
                    nb_reg  <= AXIS_LAST;
                    ret_reg <= ST_NX;
                    state_reg <= dz_direct ? ST_DZ_Y : ST_DIV;
                end
                ST_NX:   state_reg <= ST_DZ_Y;
                ST_DZ_Y:
                begin
                    cnt_reg <= '0;
                    nb_reg  <= AXIS_LAST;
                    ret_reg <= ST_NY;
                    state_reg <= dz_direct ? ST_MX0 : ST_DIV;
                end
                ST_NY:   state_reg <= ST_MX0;
                ST_MX0, ST_MX1, ST_MY0, ST_MY1:
                begin
                    cnt_reg <= '0;
                    nb_reg  <= NB_AXIS;
                    sub_reg <= 1'b0;
                    state_reg <= ST_MUL;
                    if (state_reg == ST_MX0)
                        ret_reg <= ST_MX1;
                    else if (state_reg == ST_MX1)
                        ret_reg <= ST_SX;
                    else if (state_reg == ST_MY0)
                        ret_reg <= ST_MY1;
                    else
                        ret_reg <= ST_SY;
                end
                ST_SX, ST_SY:
                begin
                    cnt_reg <= '0;
                    nb_reg  <= NB_U16;
                    sub_reg <= 1'b0;
                    ret_reg <= (state_reg == ST_SX) ? ST_VX : ST_VY;
                    state_reg <= ST_MUL;
                end
                ST_VX:
                begin
                    vel_x_reg <= vel_sat;
                    state_reg <= ST_MY0;
                end
                ST_VY:
                begin
                    vel_y_reg <= vel_sat;
                    state_reg <= ST_FIN;
                end
                ST_Q0:
                begin
                    cos_pass_reg <= 1'b0;
                    state_reg <= local_mode_reg ? ST_SIN0 : ST_PX0;
                end
                ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3:
                begin
                    cnt_reg <= '0;
                    nb_reg  <= NB_W32;
                    sub_reg <= 1'b0;
                    ret_reg <= state_reg + 5'd1;
                    state_reg <= ST_MUL;
                end
                ST_SIN4:
                begin
                    cos_pass_reg <= 1'b1;
                    state_reg <= cos_pass_reg ? ST_RX0 : ST_SIN0;
                end
                ST_RX0, ST_RX1, ST_RX2, ST_RY1:
                begin
                    cnt_reg <= '0;
                    nb_reg  <= NB_W32;
                    sub_reg <= (state_reg == ST_RX1);
                    ret_reg <= state_reg + 5'd1;
                    state_reg <= ST_MUL;
                end
                ST_RY2:  state_reg <= ST_PX0;
                ST_PX0, ST_PX1:
                begin
                    cnt_reg <= '0;
                    nb_reg  <= NB_U16;
                    sub_reg <= 1'b0;
                    ret_reg <= (state_reg == ST_PX0) ? ST_PX1 : ST_PY1;
                    state_reg <= ST_MUL;
                end
                ST_PY1:  state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (fin_load)
                        state_reg <= ST_IDLE;
                end
                ST_MUL, ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == nb_reg)
                        state_reg <= ret_reg;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= operation;
            ax_reg    <= axis_x;
            ay_reg    <= axis_y;
            px_in_reg <= pos_x;
            py_in_reg <= pos_y;
            head_reg  <= heading;
            hor_reg   <= horizon;
        end

        if (fin_load)
        begin
            vel_x_out_reg <= vel_x_reg;
            vel_y_out_reg <= vel_y_reg;
            pos_x_out_reg <= op_reg ? npx_reg : '0;
            pos_y_out_reg <= op_reg ? npy_reg : '0;
        end

        case (state_reg)
            ST_DZ_X, ST_DZ_Y:
            begin
                // load the divider with the excess over the dead zone
                if (state_reg == ST_DZ_X)
                    nx_reg <= direct_val;
                else
                    ny_reg <= direct_val;
                rem_reg  <= {1'b0, mag - d_n};
                dvs_reg  <= FS_N - d_n;
                quo_reg  <= '0;
                dneg_reg <= axis_cur[AXIS_BITS-1];
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? div_cand - {1'b0, dvs_reg} : div_cand;
                quo_reg <= {quo_reg[AXIS_BITS-2:0], div_ge};
            end
            ST_NX: nx_reg <= div_val;
            ST_NY: ny_reg <= div_val;
            ST_MX0:
            begin
                acc_reg <= '0;
                mc_reg  <= 64'(gxx_reg);
                mp_reg  <= 32'(nx_reg);
            end
            ST_MX1:
            begin
                mc_reg <= 64'(gxy_reg);
                mp_reg <= 32'(ny_reg);
            end
            ST_MY0:
            begin
                acc_reg <= '0;
                mc_reg  <= 64'(gyx_reg);
                mp_reg  <= 32'(nx_reg);
            end
            ST_MY1:
            begin
                mc_reg <= 64'(gyy_reg);
                mp_reg <= 32'(ny_reg);
            end
            ST_SX, ST_SY:
            begin
                acc_reg <= '0;
                mc_reg  <= acc_reg;
                mp_reg  <= (state_reg == ST_SX) ? $signed({16'b0, spd_x_reg})
                                                : $signed({16'b0, spd_y_reg});
            end
            ST_Q0:
            begin
                rx_reg <= 34'(vel_x_reg);
                ry_reg <= 34'(vel_y_reg);
            end
            ST_SIN0:
            begin
                acc_reg  <= '0;
                z_reg    <= zval;
                quad_reg <= quad;
                mc_reg   <= $signed(64'(zval));
                mp_reg   <= $signed({1'b0, zval});
            end
            ST_SIN1:
            begin
                z2_reg  <= sh30;
                acc_reg <= '0;
                mc_reg  <= $signed(64'(COEF_C));
                mp_reg  <= $signed({1'b0, sh30});
            end
            ST_SIN2:
            begin
                acc_reg <= '0;
                mc_reg  <= $signed(64'(COEF_B - sh30));
                mp_reg  <= $signed({1'b0, z2_reg});
            end
            ST_SIN3:
            begin
                acc_reg <= '0;
                mc_reg  <= $signed(64'(COEF_A - sh30));
                mp_reg  <= $signed({1'b0, z_reg});
            end
            ST_SIN4:
            begin
                if (cos_pass_reg)
                    c_reg <= sine_val;
                else
                    s_reg <= sine_val;
            end
            ST_RX0:
            begin
                acc_reg <= '0;
                mc_reg  <= 64'(c_reg);
                mp_reg  <= vel_x_reg;
            end
            ST_RX1:
            begin
                mc_reg <= 64'(s_reg);
                mp_reg <= vel_y_reg;
            end
            ST_RX2:
            begin
                rx_reg  <= rot_rnd[33:0];
                acc_reg <= '0;
                mc_reg  <= 64'(s_reg);
                mp_reg  <= vel_x_reg;
            end
            ST_RY1:
            begin
                mc_reg <= 64'(c_reg);
                mp_reg <= vel_y_reg;
            end
            ST_RY2: ry_reg <= rot_rnd[33:0];
            ST_PX0:
            begin
                acc_reg <= '0;
                mc_reg  <= 64'(rx_reg);
                mp_reg  <= $signed({16'b0, hor_reg});
            end
            ST_PX1:
            begin
                npx_reg <= pos_sat;
                acc_reg <= '0;
                mc_reg  <= 64'(ry_reg);
                mp_reg  <= $signed({16'b0, hor_reg});
            end
            ST_PY1: npy_reg <= pos_sat;
            ST_MUL:
            begin
                // advance one multiplier bit
                acc_reg <= acc_step;
                mc_reg  <= mc_reg <<< 1;
                mp_reg  <= mp_reg >>> 1;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign vel_x     = vel_x_out_reg;
    assign vel_y     = vel_y_out_reg;
    assign new_pos_x = pos_x_out_reg;
    assign new_pos_y = pos_y_out_reg;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, state_reg != ST_IDLE, "engine idle after accept")
    `ASSERT_IMPLIES(a_mul_count, clk, rst_n, state_reg == ST_MUL, cnt_reg <= nb_reg, "multiplier count overrun")
    `ASSERT_IMPLIES(a_div_rem, clk, rst_n, (state_reg == ST_DIV) && (cnt_reg != 5'd0), rem_reg < {1'b0, dvs_reg}, "divider remainder not below divisor")
    `ASSERT_IMPLIES(a_out_from_fin, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_FIN, "result raised outside final state")

endmodule

`default_nettype wire

// File: tb/joystick_velocity_reference_unit_tb.sv
// Self-checking testbench for the joystick velocity reference unit.
`timescale 1ns / 100ps
`default_nettype none

module joystick_velocity_reference_unit_tb;
    import jvr_pkg::*;

    localparam int AXIS_W  = 16;
    localparam int FULL    = 1 << (AXIS_W - 1);
    localparam int DRAIN   = 600;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef enum logic { OP_SAMPLE = 1'b0, OP_QUERY = 1'b1 } op_e;

    typedef struct packed {
        logic               op;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        hdg;
        logic [15:0]        hor;
    } stick_beat_t;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } motion_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    reg_index_t cfg_index;
    cfg_data_t cfg_data;
    logic in_valid;
    logic in_ready;
    logic operation;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0] heading;
    logic [15:0] horizon;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;

    joystick_velocity_reference_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .axis_x(axis_x), .axis_y(axis_y),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .horizon(horizon),
        .out_valid(out_valid), .out_ready(out_ready),
        .vel_x(vel_x), .vel_y(vel_y), .new_pos_x(new_pos_x), .new_pos_y(new_pos_y)
    );

    // Shadow copy of the configuration and velocity state
    longint dz_width;
    bit     local_mode;
    longint gxx, gxy, gyx, gyy;
    longint spd_x, spd_y;
    longint vel_state_x, vel_state_y;

    stick_beat_t pending_beats[$];
    motion_t     expected_motion[$];
    int  errors;
    longint cycle_count;
    int  send_gap;
    int  recv_gap;
    int  hold_off;
    bit  stim_done;

    // Cfg write requests, handed from the stimulus process to the driver
    bit         cfg_req;
    reg_index_t cfg_req_idx;
    cfg_data_t  cfg_req_data;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint round_shift(longint v, int s);
        longint h;
        h = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + h) >>> s;
        return -((-v + h - 1) >>> s);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint shape_axis(longint a);
        longint mag;
        longint r;
        if (dz_width >= FULL)
            return a;
        mag = (a < 0) ? -a : a;
        if (mag <= dz_width)
            return 0;
        r = ((mag - dz_width) << (AXIS_W - 1)) / (FULL - dz_width);
        return (a < 0) ? -r : r;
    endfunction

    // Quarter-wave polynomial sine in Q16 for a 16-bit binary angle
    function automatic longint sine_q16(logic [15:0] h);
        logic [1:0] quad;
        longint r;
        longint z;
        longint z2;
        longint t;
        quad = h[15:14];
        r = longint'(h[13:0]);
        if (quad[0])
            r = 16384 - r;
        z = r << 16;
        z2 = (z * z) >>> 30;
        t = (longint'(COEF_C) * z2) >>> 30;
        t = ((longint'(COEF_B) - t) * z2) >>> 30;
        t = ((longint'(COEF_A) - t) * z) >>> 30;
        t = (t + 8192) >>> 14;
        return quad[1] ? -t : t;
    endfunction

    function automatic void apply_register(reg_index_t idx, cfg_data_t d);
        case (idx)
            REG_DEADZONE_WIDTH:   dz_width = longint'(d);
            REG_LOCAL_FRAME_MODE: local_mode = d[0];
            REG_X_GAIN_FROM_X:    gxx = longint'(signed'(d));
            REG_X_GAIN_FROM_Y:    gxy = longint'(signed'(d));
            REG_Y_GAIN_FROM_X:    gyx = longint'(signed'(d));
            REG_Y_GAIN_FROM_Y:    gyy = longint'(signed'(d));
            REG_MAX_SPEED_X:      spd_x = longint'(d);
            REG_MAX_SPEED_Y:      spd_y = longint'(d);
            default: ;
        endcase
    endfunction

    // Advance the shadow state by one beat and return the motion it produces
    function automatic motion_t predict_motion(stick_beat_t b);
        motion_t m;
        longint nx, ny, mx, my, rx, ry, s, c, hz;
        longint px, py;
        px = 0;
        py = 0;
        if (b.op == OP_SAMPLE)
        begin
            nx = shape_axis(longint'(b.ax));
            ny = shape_axis(longint'(b.ay));
            mx = gxx * nx + gxy * ny;
            my = gyx * nx + gyy * ny;
            vel_state_x = clamp32(round_shift(mx * spd_x, AXIS_W + 9));
            vel_state_y = clamp32(round_shift(my * spd_y, AXIS_W + 9));
        end
        else
        begin
            rx = vel_state_x;
            ry = vel_state_y;
            hz = longint'(b.hor);
            if (local_mode)
            begin
                s = sine_q16(b.hdg);
                c = sine_q16(b.hdg + 16'd16384);
                rx = round_shift(c * vel_state_x - s * vel_state_y, 16);
                ry = round_shift(s * vel_state_x + c * vel_state_y, 16);
            end
            px = clamp32(longint'(b.px) + round_shift(rx * hz, 12));
            py = clamp32(longint'(b.py) + round_shift(ry * hz, 12));
        end
        m.vx = vel_state_x[31:0];
        m.vy = vel_state_y[31:0];
        m.nx = px[31:0];
        m.ny = py[31:0];
        return m;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Drive the input and cfg channels; one nonblocking write per signal per edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_register(cfg_index, cfg_data);
                cfg_req = 1'b0;
            end
            if (cfg_req && !(cfg_valid && cfg_ready) && !cfg_valid)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_req_idx;
                cfg_data <= cfg_req_data;
            end
            else if (cfg_valid && cfg_ready)
                cfg_valid <= 1'b0;

            if (in_valid && in_ready)
                expected_motion.push_back(predict_motion({operation, axis_x, axis_y,
                                          pos_x, pos_y, heading, horizon}));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0 || pending_beats.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end
                else
                begin
                    stick_beat_t b;
                    b = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    operation <= b.op;
                    axis_x <= b.ax;
                    axis_y <= b.ay;
                    pos_x <= b.px;
                    pos_y <= b.py;
                    heading <= b.hdg;
                    horizon <= b.hor;
                    send_gap <= pick_gap();
                end
            end
        end
    end

    // Count the long receiver hold-off in cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_off <= 0;
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
        else if (cycle_count == 3000)
            hold_off <= 4000;
    end

    // Check each output beat against the oldest expectation and pace out_ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready)
            begin
                if (expected_motion.size() == 0)
                begin
                    $display("%0t: unexpected beat vel %0d %0d pos %0d %0d", $time,
                             vel_x, vel_y, new_pos_x, new_pos_y);
                    errors++;
                end
                else
                begin
                    motion_t e;
                    e = expected_motion.pop_front();
                    if (vel_x !== e.vx)
                    begin
                        $display("%0t: vel_x expected %0d actual %0d", $time, e.vx, vel_x);
                        errors++;
                    end
                    if (vel_y !== e.vy)
                    begin
                        $display("%0t: vel_y expected %0d actual %0d", $time, e.vy, vel_y);
                        errors++;
                    end
                    if (new_pos_x !== e.nx)
                    begin
                        $display("%0t: new_pos_x expected %0d actual %0d", $time,
                                 e.nx, new_pos_x);
                        errors++;
                    end
                    if (new_pos_y !== e.ny)
                    begin
                        $display("%0t: new_pos_y expected %0d actual %0d", $time,
                                 e.ny, new_pos_y);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
                out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    recv_gap <= pick_gap();
            end
        end
    end

    function automatic stick_beat_t random_beat(int query_pct);
        stick_beat_t b;
        int p;
        b.op = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_SAMPLE;
        p = $urandom_range(0, 9);
        b.ax = (p == 0) ? 16'h8000 : (p == 1) ? 16'h7fff : 16'($urandom);
        p = $urandom_range(0, 9);
        b.ay = (p == 0) ? 16'h8000 : (p == 1) ? 16'h7fff : 16'($urandom);
        p = $urandom_range(0, 9);
        b.px = (p == 0) ? 32'h7fffffff : (p == 1) ? 32'h80000000 : $urandom;
        b.py = (p == 2) ? 32'h7fffffff : (p == 3) ? 32'h80000000 : $urandom;
        b.hdg = 16'($urandom);
        b.hor = 16'($urandom);
        return b;
    endfunction

    function automatic stick_beat_t make_beat(op_e op, int ax, int ay,
                                              int px, int py, int hdg, int hor);
        stick_beat_t b;
        b.op = op;
        b.ax = ax[15:0];
        b.ay = ay[15:0];
        b.px = px;
        b.py = py;
        b.hdg = hdg[15:0];
        b.hor = hor[15:0];
        return b;
    endfunction

    // Write one register and wait for the beat to land
    task automatic write_register(reg_index_t idx, cfg_data_t d);
        @(posedge clk);
        cfg_req_idx = idx;
        cfg_req_data = d;
        cfg_req = 1'b1;
        while (cfg_req)
            @(posedge clk);
    endtask

    // Wait until everything sent has come back, plus the engine's tail
    task automatic drain_block();
        while (pending_beats.size() != 0 || in_valid || expected_motion.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_settings();
        int p;
        p = $urandom_range(0, 5);
        write_register(REG_DEADZONE_WIDTH, (p == 0) ? 16'd0 : (p == 1) ? 16'd32768 :
                       (p == 2) ? 16'hffff : (p == 3) ? 16'd32767 : 16'($urandom_range(0, 12000)));
        write_register(REG_LOCAL_FRAME_MODE, 16'($urandom));
        write_register(REG_X_GAIN_FROM_X, 16'($urandom));
        write_register(REG_X_GAIN_FROM_Y, 16'($urandom));
        write_register(REG_Y_GAIN_FROM_X, 16'($urandom));
        write_register(REG_Y_GAIN_FROM_Y, 16'($urandom));
        p = $urandom_range(0, 3);
        write_register(REG_MAX_SPEED_X, (p == 0) ? 16'hffff : 16'($urandom));
        write_register(REG_MAX_SPEED_Y, (p == 1) ? 16'hffff : 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            write_register(reg_index_t'($urandom_range(8, 15)), 16'($urandom));
    endtask

    initial
    begin
        errors = 0;
        stim_done = 1'b0;
        cfg_req = 1'b0;
        dz_width = 0;
        local_mode = 1'b0;
        gxx = 16384;
        gxy = 0;
        gyx = 0;
        gyy = 16384;
        spd_x = 4096;
        spd_y = 4096;
        vel_state_x = 0;
        vel_state_y = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_DEADZONE_WIDTH;
        cfg_data = '0;
        operation = OP_SAMPLE;
        axis_x = '0;
        axis_y = '0;
        pos_x = '0;
        pos_y = '0;
        heading = '0;
        horizon = '0;
        out_ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, query before any sample, axis extremes
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 100, -100, 0, 4096));
        pending_beats.push_back(make_beat(OP_SAMPLE, 32767, -32768, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 32'h7fffffff, 32'h80000000,
                                          0, 65535));
        pending_beats.push_back(make_beat(OP_SAMPLE, -32768, 32767, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 0, 0, 65535, 0));
        drain_block();

        // Dead zone wide, local frame on, big gains and speeds, heading quadrants
        write_register(REG_DEADZONE_WIDTH, 16'd8000);
        write_register(REG_LOCAL_FRAME_MODE, 16'd1);
        write_register(REG_X_GAIN_FROM_X, 16'h7fff);
        write_register(REG_X_GAIN_FROM_Y, 16'h8000);
        write_register(REG_Y_GAIN_FROM_X, 16'h8000);
        write_register(REG_Y_GAIN_FROM_Y, 16'h7fff);
        write_register(REG_MAX_SPEED_X, 16'hffff);
        write_register(REG_MAX_SPEED_Y, 16'hffff);
        pending_beats.push_back(make_beat(OP_SAMPLE, 8000, -8000, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_SAMPLE, 8001, -8001, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_SAMPLE, 32767, 32767, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 0, 0, 16'h0000, 65535));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 0, 0, 16'h4000, 65535));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 0, 0, 16'h8000, 4096));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 0, 0, 16'hc000, 4096));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 32'h7fffffff, 32'h80000000,
                                          16'h2000, 65535));
        pending_beats.push_back(make_beat(OP_SAMPLE, -32768, -32768, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 32'h80000000, 32'h7fffffff,
                                          16'h6000, 65535));
        drain_block();

        // Dead zone disabled at full scale, then just below full scale
        write_register(REG_DEADZONE_WIDTH, 16'd32768);
        pending_beats.push_back(make_beat(OP_SAMPLE, 5, -5, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_QUERY, 0, 0, 1, 2, 16'h1234, 300));
        drain_block();
        write_register(REG_DEADZONE_WIDTH, 16'd32767);
        pending_beats.push_back(make_beat(OP_SAMPLE, 32767, -32767, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_SAMPLE, -32768, 32766, 0, 0, 0, 0));
        drain_block();

        // Random phases; the receiver hold-off falls in the directed blocks before them
        for (int ph = 0; ph < 15; ph++)
        begin
            int qp;
            random_settings();
            qp = $urandom_range(20, 60);
            for (int k = 0; k < 70; k++)
                pending_beats.push_back(random_beat(qp));
            drain_block();
        end
        stim_done = 1'b1;
        if (errors == 0)
            $display("joystick_velocity_reference_unit verification clean");
        else
            $display("joystick_velocity_reference_unit verification failed");
        $finish;
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT && !stim_done)
        begin
            $display("joystick_velocity_reference_unit verification failed");
            $finish;
        end
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/jvr_pkg.sv
hw/rtl/joystick_velocity_reference_unit.sv
tb/joystick_velocity_reference_unit_tb.sv
